>>> hw/rtl/wtepm_pkg.sv
// Shared constants, codes and types of the write-then-execute page monitor.
`default_nettype none

package wtepm_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int OFFSET_BITS   = 12;

    localparam int SPACE_W = 64;
    localparam int PAGE_W  = 52;
    localparam int OFS_W   = 12;
    localparam int ADDR_W  = 64;
    localparam int CNT_W   = 6;
    localparam int OP_W    = 3;
    localparam int ST_W    = 2;

    localparam logic [CNT_W-1:0] COUNT_MAX  = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] THR_RESET  = CNT_W'(32);

    typedef enum logic [OP_W-1:0] {
        OP_WATCH       = 3'd0,
        OP_UNWATCH     = 3'd1,
        OP_UNWATCH_SPC = 3'd2,
        OP_CLEAR_ALL   = 3'd3,
        OP_WRITE_EVT   = 3'd4,
        OP_EXEC_EVT    = 3'd5
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_ALREADY = 2'd2,
        ST_MISS    = 2'd3
    } t_status;

    // what one table slot shows the decision logic
    typedef struct packed {
        logic             used;
        logic             space_eq;
        logic             page_eq;
        logic             dirty;
        logic [CNT_W-1:0] count;
        logic             exec;
    } t_entry_view;

    // update of one table slot
    typedef struct packed {
        logic             load;
        logic             free;
        logic             upd;
        logic             dirty;
        logic [CNT_W-1:0] count;
        logic             exec;
    } t_entry_cmd;

    typedef struct packed {
        t_status           status;
        logic              unpacked;
        logic [SPACE_W-1:0] rspace;
        logic [ADDR_W-1:0]  raddr;
    } t_result;

endpackage

`default_nettype wire

>>> hw/rtl/wtepm_entry.sv
// One slot of the watched-page table: key, phase state and key compare.
`default_nettype none

module wtepm_entry (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wtepm_pkg::t_entry_cmd             i_cmd,
    input  wire [wtepm_pkg::SPACE_W-1:0]      i_space,
    input  wire [wtepm_pkg::PAGE_W-1:0]       i_page,
    output wtepm_pkg::t_entry_view            o_view
);
    import wtepm_pkg::*;

    logic               r_used;
    logic [SPACE_W-1:0] r_space;
    logic [PAGE_W-1:0]  r_page;
    logic               r_dirty;
    logic [CNT_W-1:0]   r_count;
    logic               r_exec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_cmd.load) begin
            r_used <= 1'b1;
        end else if (i_cmd.free) begin
            r_used <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_space <= i_space;
            r_page  <= i_page;
            r_dirty <= 1'b0;
            r_count <= '0;
            r_exec  <= 1'b0;
        end else if (i_cmd.upd) begin
            r_dirty <= i_cmd.dirty;
            r_count <= i_cmd.count;
            r_exec  <= i_cmd.exec;
        end
    end

    assign o_view.used     = r_used;
    assign o_view.space_eq = (r_space == i_space);
    assign o_view.page_eq  = (r_page == i_page);
    assign o_view.dirty    = r_dirty;
    assign o_view.count    = r_count;
    assign o_view.exec     = r_exec;

endmodule

`default_nettype wire

>>> hw/rtl/wtepm_decide.sv
// Command decode: picks the slot, builds slot updates and the result beat.
`default_nettype none

module wtepm_decide (
    input  wire [wtepm_pkg::OP_W-1:0]                              i_op,
    input  wire                                                    i_write_valid,
    input  wire [wtepm_pkg::CNT_W-1:0]                             i_thr,
    input  wire [wtepm_pkg::SPACE_W-1:0]                           i_space,
    input  wire [wtepm_pkg::PAGE_W-1:0]                            i_page,
    input  wire [wtepm_pkg::OFS_W-1:0]                             i_offset,
    input  wtepm_pkg::t_entry_view [wtepm_pkg::TABLE_ENTRIES-1:0]  i_view,
    output wtepm_pkg::t_entry_cmd  [wtepm_pkg::TABLE_ENTRIES-1:0]  o_cmd,
    output wtepm_pkg::t_result                                     o_res
);
    import wtepm_pkg::*;

    logic [TABLE_ENTRIES-1:0] hit_vec;
    logic [TABLE_ENTRIES-1:0] free_vec;
    logic [TABLE_ENTRIES-1:0] spc_vec;
    logic [IDX_W-1:0]         hit_idx;
    logic [IDX_W-1:0]         free_idx;
    logic                     hit_any;
    logic                     free_any;
    t_entry_view              hv;
    logic [CNT_W-1:0]         new_cnt;

    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            hit_vec[i]  = i_view[i].used & i_view[i].space_eq & i_view[i].page_eq;
            free_vec[i] = ~i_view[i].used;
            spc_vec[i]  = i_view[i].used & i_view[i].space_eq;
        end
        // lowest index wins
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_idx = IDX_W'(i);
            end
            if (free_vec[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign hit_any  = |hit_vec;
    assign free_any = |free_vec;
    assign hv       = i_view[hit_idx];

    // invalid writes count up, stopping at the top
    assign new_cnt = (!i_write_valid && hv.count != COUNT_MAX) ? hv.count + CNT_W'(1)
                                                                : hv.count;

    always_comb begin
        o_cmd        = '0;
        o_res        = '0;
        o_res.status = ST_DONE;
        case (t_op'(i_op))
            OP_WATCH: begin
                if (hit_any) begin
                    o_res.status = ST_ALREADY;
                end else if (free_any) begin
                    o_cmd[free_idx].load = 1'b1;
                end else begin
                    o_res.status = ST_FULL;
                end
            end
            OP_UNWATCH: begin
                if (hit_any) begin
                    o_cmd[hit_idx].free = 1'b1;
                end else begin
                    o_res.status = ST_MISS;
                end
            end
            OP_UNWATCH_SPC: begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    o_cmd[i].free = spc_vec[i];
                end
                if (!(|spc_vec)) begin
                    o_res.status = ST_MISS;
                end
            end
            OP_CLEAR_ALL: begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    o_cmd[i].free = 1'b1;
                end
            end
            OP_WRITE_EVT: begin
                if (!hit_any || hv.exec) begin
                    o_res.status = ST_MISS;
                end else begin
                    o_cmd[hit_idx].upd   = 1'b1;
                    o_cmd[hit_idx].dirty = hv.dirty | ~i_write_valid;
                    o_cmd[hit_idx].count = new_cnt;
                    o_cmd[hit_idx].exec  = (new_cnt >= i_thr);
                end
            end
            OP_EXEC_EVT: begin
                if (!hit_any || !hv.exec) begin
                    o_res.status = ST_MISS;
                end else begin
                    o_cmd[hit_idx].free = 1'b1;
                    if (hv.dirty) begin
                        // key matched, so the slot's space and page equal the event's
                        o_res.unpacked = 1'b1;
                        o_res.rspace   = i_space;
                        o_res.raddr    = ({{(ADDR_W-PAGE_W){1'b0}}, i_page} << OFFSET_BITS)
                                       + {{(ADDR_W-OFS_W){1'b0}}, i_offset};
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/write_then_execute_page_monitor_unit.sv
// Top level of the write-then-execute page monitor.
//
// Command channel: drive op, space, page, offset and write_valid with start
// high; a beat is taken on each rising edge with start high and busy low.
// busy stays low, so a new command can be issued every cycle.
// Each command yields exactly one result beat, shown for one cycle with
// o_result_valid high; it passes the input register, then the table
// compare/update into the result register. Throughput: one
// command per cycle, set by the combinational parallel tag compare over the
// table slots. Back-to-back commands see each other's table updates.
// The receiver cannot stall: results are not held.
// Threshold register: i_cfg_we with i_cfg_wdata writes it on the edge;
// write only while no command is in flight.
// Reset (synchronous, active low) empties the table, drops in-flight beats
// and sets the threshold to 32. Slot contents are loaded on watch.
`default_nettype none

module write_then_execute_page_monitor_unit (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             start,
    output wire                             busy,
    input  wire [wtepm_pkg::OP_W-1:0]       i_op,
    input  wire [wtepm_pkg::SPACE_W-1:0]    i_space_id,
    input  wire [wtepm_pkg::PAGE_W-1:0]     i_page_number,
    input  wire [wtepm_pkg::OFS_W-1:0]      i_page_offset,
    input  wire                             i_write_valid,
    input  wire                             i_cfg_we,
    input  wire [wtepm_pkg::CNT_W-1:0]      i_cfg_wdata,
    output wire                             o_result_valid,
    output wire [wtepm_pkg::ST_W-1:0]       o_status,
    output wire                             o_unpacked,
    output wire [wtepm_pkg::SPACE_W-1:0]    o_report_space,
    output wire [wtepm_pkg::ADDR_W-1:0]     o_report_address
);
    import wtepm_pkg::*;

    logic               r_thr;
    logic [CNT_W-1:0]   r_threshold;
    logic               r_in_vld;
    logic [OP_W-1:0]    r_op;
    logic [SPACE_W-1:0] r_space;
    logic [PAGE_W-1:0]  r_page;
    logic [OFS_W-1:0]   r_offset;
    logic               r_wvalid;
    logic               r_res_vld;
    t_result            r_res;
    t_result            n_res;
    logic               accept;

    t_entry_view [TABLE_ENTRIES-1:0] view;
    t_entry_cmd  [TABLE_ENTRIES-1:0] cmd;
    t_entry_cmd  [TABLE_ENTRIES-1:0] cmd_gated;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THR_RESET;
            r_thr       <= 1'b0;
            r_in_vld    <= 1'b0;
            r_res_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_threshold <= i_cfg_wdata;
            end
            r_thr     <= i_cfg_we;
            r_in_vld  <= accept;
            r_res_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_op;
            r_space  <= i_space_id;
            r_page   <= i_page_number;
            r_offset <= i_page_offset;
            r_wvalid <= i_write_valid;
        end
        if (r_in_vld) begin
            r_res <= n_res;
        end
    end

    wtepm_decide u_decide (
        .i_op          (r_op),
        .i_write_valid (r_wvalid),
        .i_thr         (r_threshold),
        .i_space       (r_space),
        .i_page        (r_page),
        .i_offset      (r_offset),
        .i_view        (view),
        .o_cmd         (cmd),
        .o_res         (n_res)
    );

    // table changes only for a live beat
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            cmd_gated[i]      = cmd[i];
            cmd_gated[i].load = cmd[i].load & r_in_vld;
            cmd_gated[i].free = cmd[i].free & r_in_vld;
            cmd_gated[i].upd  = cmd[i].upd & r_in_vld;
        end
    end

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_slot
        wtepm_entry u_entry (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd_gated[g]),
            .i_space (r_space),
            .i_page  (r_page),
            .o_view  (view[g])
        );
    end

    assign o_result_valid   = r_res_vld;
    assign o_status         = r_res.status;
    assign o_unpacked       = r_res.unpacked;
    assign o_report_space   = r_res.rspace;
    assign o_report_address = r_res.raddr;

    // every command beat produces its result beat through the input and result registers
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_result_valid)
        else $error("result beat missing after command");

    // an unpack report is always a completed command
    a_unpack_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_unpacked) |-> (o_status == ST_DONE))
        else $error("unpack reported with failing status");

    // report fields are zero unless an unpack is reported
    a_report_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_unpacked) |->
            (o_report_space == '0 && o_report_address == '0))
        else $error("report fields set without unpack");

    // a key is never present in two slots
    a_unique_key: assert property (@(posedge i_clk) disable iff (!i_rst_n || r_thr)
        r_in_vld |-> ($countones(u_decide.hit_vec) <= 1))
        else $error("duplicate page in table");

endmodule

`default_nettype wire
